// ===== hdl/bitmap_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define BBA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`else

`define BBA_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, request codes and status codes shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int FUNC_W      = 2;
    localparam int INDEX_W     = 12;
    localparam int BLOCK_LIMIT = 4096;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_MARK  = 2'd2
    } func_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/bba_channels.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Valid/ready interfaces for the request and response streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
    logic                              valid;
    logic                              ready;
    logic [bba_pkg::FUNC_W-1:0]        func;
    logic [bba_pkg::INDEX_W-1:0]       block_index;

    modport source (output valid, output func, output block_index, input ready);
    modport sink   (input valid, input func, input block_index, output ready);
endinterface

interface bba_resp_if;
    logic                              valid;
    logic                              ready;
    logic [bba_pkg::INDEX_W-1:0]       block_number;
    logic                              status;

    modport source (output valid, output block_number, output status, input ready);
    modport sink   (input valid, input block_number, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bba_block_split.sv =====
// ----------------------------------------------------------------------------
// Block number split
// Two-stage divide of a block number by the word width, giving the word
// index and the bit index, using a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_block_split #(
    parameter int WORD_BITS = 16,
    localparam int Q_W      = $clog2((bba_pkg::BLOCK_LIMIT - 1) / WORD_BITS + 1),
    localparam int BIT_W    = $clog2(WORD_BITS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bba_pkg::INDEX_W-1:0]   block_index,
    output logic                          done,
    output logic [Q_W-1:0]                word_index,
    output logic [BIT_W-1:0]              bit_index
);

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = bba_pkg::INDEX_W + RECIP_W;

    localparam logic [bba_pkg::INDEX_W-1:0] WB_C = bba_pkg::INDEX_W'(WORD_BITS);

    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic [Q_W-1:0]                q0_reg;
    logic [bba_pkg::INDEX_W-1:0]   idx1_reg;
    logic [Q_W-1:0]                word_reg;
    logic [BIT_W-1:0]              bit_reg;

    logic [PROD_W-1:0]             prod;
    logic [bba_pkg::INDEX_W-1:0]   base;
    logic [bba_pkg::INDEX_W-1:0]   rem0;
    logic [Q_W-1:0]                word_next;
    logic [BIT_W-1:0]              bit_next;

    assign prod = PROD_W'(block_index) * PROD_W'(RECIP);
    assign base = bba_pkg::INDEX_W'(q0_reg) * WB_C;
    assign rem0 = idx1_reg - base;

    always_comb
    begin
        if (rem0 >= WB_C)
        begin
            word_next = q0_reg + Q_W'(1);
            bit_next  = BIT_W'(rem0 - WB_C);
        end
        else
        begin
            word_next = q0_reg;
            bit_next  = BIT_W'(rem0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg   <= Q_W'(prod >> RECIP_SHIFT);
        idx1_reg <= block_index;
        word_reg <= word_next;
        bit_reg  <= bit_next;
    end

    assign done       = s2_valid_reg;
    assign word_index = word_reg;
    assign bit_index  = bit_reg;

endmodule

`default_nettype wire

// ===== hdl/bba_first_clear.sv =====
// ----------------------------------------------------------------------------
// First clear bit finder
// Priority encoder that returns the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_first_clear #(
    parameter int WORD_BITS = 16,
    localparam int BIT_W    = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    output logic                 found,
    output logic [BIT_W-1:0]     bit_index
);

    always_comb
    begin
        bit_index = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                bit_index = BIT_W'(i);
            end
        end
    end

    assign found = ~&word;

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a free-block bitmap held in a synchronous memory.
// Requests allocate the lowest free block, free a block or mark it used.
//
//   Channel | Direction | Payload                     | Transfer when
//   --------+-----------+-----------------------------+------------------
//   req     | in        | func, block_index           | valid && ready
//   resp    | out       | block_number, status        | valid && ready
//
// Free and mark pass through the block number split, one memory read and
// one write-back before the response.
// Allocate reads one bitmap word per cycle through the single memory read
// port, up to SCAN_WORDS words, and stops at the first word with a clear bit.
// After reset a clearing pass writes every bitmap word, one per cycle,
// and req is not ready until it ends.
// A response waits in an output register; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
    parameter int BITMAP_WORDS    = 256,
    parameter int WORD_BITS       = 16,
    parameter int RESERVED_BLOCKS = 35
) (
    input  logic        clk,
    input  logic        rst_n,
    bba_req_if.sink     req,
    bba_resp_if.source  resp
);

    localparam int ADDR_W     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int Q_W        = $clog2((bba_pkg::BLOCK_LIMIT - 1) / WORD_BITS + 1);
    localparam int SPAN_WORDS = (bba_pkg::BLOCK_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int SCAN_WORDS = (BITMAP_WORDS < SPAN_WORDS) ? BITMAP_WORDS : SPAN_WORDS;
    localparam int LAST_ROOM  = bba_pkg::BLOCK_LIMIT - (SCAN_WORDS - 1) * WORD_BITS;
    localparam int LAST_VALID = (LAST_ROOM < WORD_BITS) ? LAST_ROOM : WORD_BITS;
    localparam int CMP_W      =
        $clog2(BITMAP_WORDS * WORD_BITS + WORD_BITS + bba_pkg::BLOCK_LIMIT + 1);

    localparam logic [ADDR_W-1:0]    SCAN_LAST = ADDR_W'(SCAN_WORDS - 1);
    localparam logic [ADDR_W-1:0]    WORD_LAST = ADDR_W'(BITMAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_PAD  = {WORD_BITS{1'b1}} << LAST_VALID;
    localparam logic [CMP_W-1:0]     RES_C     = CMP_W'(RESERVED_BLOCKS);
    localparam logic [CMP_W-1:0]     WB_C      = CMP_W'(WORD_BITS);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SPLIT = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    logic [WORD_BITS-1:0]          bitmap_mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0]          mem_rd_data_reg;
    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic [WORD_BITS-1:0]          mem_wr_data;

    state_t                        state_reg, state_next;
    logic [ADDR_W-1:0]             clr_addr_reg, clr_addr_next;
    logic [CMP_W-1:0]              clr_base_reg, clr_base_next;
    logic [ADDR_W-1:0]             scan_addr_reg, scan_addr_next;
    logic                          issue_done_reg, issue_done_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic                          out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]             rd_addr_q_reg, rd_addr_q_next;
    logic [bba_pkg::FUNC_W-1:0]    func_reg, func_next;
    logic [ADDR_W-1:0]             pend_addr_reg, pend_addr_next;
    logic [BIT_W-1:0]              pend_bit_reg, pend_bit_next;
    logic [bba_pkg::INDEX_W-1:0]   res_number_reg, res_number_next;
    logic                          res_status_reg, res_status_next;
    logic [bba_pkg::INDEX_W-1:0]   out_number_reg, out_number_next;
    logic                          out_status_reg, out_status_next;

    logic [CMP_W-1:0]              clr_end;
    logic [CMP_W-1:0]              clr_gap;
    logic [WORD_BITS-1:0]          clr_word;

    logic                          split_start;
    logic                          split_done;
    logic [Q_W-1:0]                split_word;
    logic [BIT_W-1:0]              split_bit;

    logic [WORD_BITS-1:0]          scan_word;
    logic                          enc_found;
    logic [BIT_W-1:0]              enc_bit;
    logic                          hit;
    logic                          full_last;
    logic [WORD_BITS-1:0]          hit_mask;
    logic [WORD_BITS-1:0]          pend_mask;

    bba_block_split #(
        .WORD_BITS   (WORD_BITS)
    ) u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (split_start),
        .block_index (req.block_index),
        .done        (split_done),
        .word_index  (split_word),
        .bit_index   (split_bit)
    );

    bba_first_clear #(
        .WORD_BITS   (WORD_BITS)
    ) u_first_clear (
        .word        (scan_word),
        .found       (enc_found),
        .bit_index   (enc_bit)
    );

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            bitmap_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rd_data_reg <= bitmap_mem[mem_rd_addr];
        end
    end

    always_comb
    begin
        clr_end = clr_base_reg + WB_C;
        clr_gap = RES_C - clr_base_reg;
        if (clr_end <= RES_C)
        begin
            clr_word = '1;
        end
        else if (clr_base_reg >= RES_C)
        begin
            clr_word = '0;
        end
        else
        begin
            clr_word = ~({WORD_BITS{1'b1}} << clr_gap[BIT_W-1:0]);
        end
    end

    assign scan_word = mem_rd_data_reg | ((rd_addr_q_reg == SCAN_LAST) ? LAST_PAD : '0);
    assign hit       = rd_valid_reg && enc_found;
    assign full_last = rd_valid_reg && !enc_found && (rd_addr_q_reg == SCAN_LAST);
    assign hit_mask  = WORD_BITS'(1) << enc_bit;
    assign pend_mask = WORD_BITS'(1) << pend_bit_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_base_next   = clr_base_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = 1'b0;
        rd_addr_q_next  = scan_addr_reg;
        func_next       = func_reg;
        pend_addr_next  = pend_addr_reg;
        pend_bit_next   = pend_bit_reg;
        res_number_next = res_number_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !resp.ready;
        out_number_next = out_number_reg;
        out_status_next = out_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = scan_addr_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = clr_addr_reg;
        mem_wr_data     = clr_word;
        split_start     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                clr_base_next = clr_base_reg + WB_C;
                if (clr_addr_reg == WORD_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next       = req.func;
                    res_number_next = req.block_index;
                    res_status_next = bba_pkg::STATUS_OK;
                    unique case (req.func) inside
                        bba_pkg::FUNC_ALLOC:
                        begin
                            scan_addr_next  = '0;
                            issue_done_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        bba_pkg::FUNC_FREE, bba_pkg::FUNC_MARK:
                        begin
                            split_start = 1'b1;
                            state_next  = ST_SPLIT;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SPLIT:
            begin
                if (split_done)
                begin
                    pend_bit_next = split_bit;
                    if (32'(split_word) < 32'(BITMAP_WORDS))
                    begin
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = ADDR_W'(split_word);
                        pend_addr_next = ADDR_W'(split_word);
                        state_next     = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_FETCH:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pend_addr_reg;
                if (func_reg == bba_pkg::FUNC_FREE)
                begin
                    mem_wr_data = mem_rd_data_reg & ~pend_mask;
                end
                else
                begin
                    mem_wr_data = mem_rd_data_reg | pend_mask;
                end
                state_next = ST_RESP;
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = rd_addr_q_reg;
                    mem_wr_data     = mem_rd_data_reg | hit_mask;
                    res_number_next = bba_pkg::INDEX_W'(rd_addr_q_reg)
                                      * bba_pkg::INDEX_W'(WORD_BITS)
                                      + bba_pkg::INDEX_W'(enc_bit);
                    res_status_next = bba_pkg::STATUS_OK;
                    state_next      = ST_RESP;
                end
                else if (full_last)
                begin
                    res_number_next = '0;
                    res_status_next = bba_pkg::STATUS_FULL;
                    state_next      = ST_RESP;
                end
                else if (!issue_done_reg)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = scan_addr_reg;
                    rd_valid_next  = 1'b1;
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                    if (scan_addr_reg == SCAN_LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_number_next = res_number_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_base_reg   <= '0;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_base_reg   <= clr_base_next;
            scan_addr_reg  <= scan_addr_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_q_reg  <= rd_addr_q_next;
        func_reg       <= func_next;
        pend_addr_reg  <= pend_addr_next;
        pend_bit_reg   <= pend_bit_next;
        res_number_reg <= res_number_next;
        res_status_reg <= res_status_next;
        out_number_reg <= out_number_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign resp.valid        = out_valid_reg;
    assign resp.block_number = out_number_reg;
    assign resp.status       = out_status_reg;

    `BBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, req.valid && req.ready, !req.ready)
    `BBA_ASSERT_SAME(a_no_rw_clash, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
    `BBA_ASSERT_SAME(a_full_zero, clk, rst_n, resp.valid && resp.status, resp.block_number == '0)
    `BBA_ASSERT_SAME(a_clear_quiet, clk, rst_n, state_reg == ST_CLEAR, !req.ready && !mem_rd_en)

endmodule

`default_nettype wire

// ===== sim/alloc_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the request and response channels, keeps its own copy of the
// block usage bitmap, predicts the response of every request transfer and
// compares each response transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alloc_checker
    import bba_pkg::*;
#(
    parameter int MAP_WORDS = 256,
    parameter int MAP_BITS  = 16,
    parameter int RESERVED  = 35
) (
    input  logic clk,
    input  logic rst_n,
    bba_req_if   req,
    bba_resp_if  resp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [INDEX_W-1:0] block_number;
        logic               status;
    } grant_t;

    logic [MAP_BITS-1:0] used_map [MAP_WORDS];
    grant_t              expected_grants [$];
    grant_t              oldest_grant;
    int                  mismatches;

    function automatic grant_t apply_request(input logic [FUNC_W-1:0] code,
                                             input logic [INDEX_W-1:0] idx);
        grant_t grant;
        int     word;
        grant.block_number = idx;
        grant.status       = STATUS_OK;
        word               = idx / MAP_BITS;
        case (code)
            FUNC_ALLOC:
            begin
                grant.block_number = '0;
                grant.status       = STATUS_FULL;
                for (int w = 0; w < MAP_WORDS && grant.status == STATUS_FULL; w++)
                    for (int b = 0; b < MAP_BITS && grant.status == STATUS_FULL; b++)
                        if (!used_map[w][b] && w * MAP_BITS + b < BLOCK_LIMIT)
                        begin
                            used_map[w][b]     = 1'b1;
                            grant.block_number = INDEX_W'(w * MAP_BITS + b);
                            grant.status       = STATUS_OK;
                        end
            end
            FUNC_FREE:
            begin
                if (word < MAP_WORDS)
                    used_map[word][idx % MAP_BITS] = 1'b0;
            end
            FUNC_MARK:
            begin
                if (word < MAP_WORDS)
                    used_map[word][idx % MAP_BITS] = 1'b1;
            end
            default:
            begin
            end
        endcase
        return grant;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
                for (int b = 0; b < MAP_BITS; b++)
                    used_map[w][b] = (w * MAP_BITS + b < RESERVED);
            expected_grants.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (resp.valid && resp.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected response transfer: block_number %0d, status %0d",
                           resp.block_number, resp.status);
                    mismatches++;
                end
                else
                begin
                    oldest_grant = expected_grants.pop_front();
                    if (resp.block_number !== oldest_grant.block_number)
                    begin
                        $error("block_number mismatch: expected %0d, actual %0d",
                               oldest_grant.block_number, resp.block_number);
                        mismatches++;
                    end
                    if (resp.status !== oldest_grant.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_grant.status, resp.status);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_grants.push_back(apply_request(req.func, req.block_index));
            fail_count <= mismatches;
            pending    <= expected_grants.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free, mark and unused-code requests into the allocator:
// a directed pass over boundary blocks, random traffic under three idling
// patterns, and closing frees and allocations around the last block and at
// random blocks. The checker predicts and compares every response transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                LAST_BLOCK  = BLOCK_LIMIT - 1;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   fail_count;
    int   pending;

    bba_req_if  req_ch ();
    bba_resp_if resp_ch ();

    bitmap_block_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    alloc_checker grant_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .resp       (resp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
        resp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic send_request(input logic [FUNC_W-1:0] code,
                                input logic [INDEX_W-1:0] idx);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= code;
        req_ch.block_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_requests;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int                 pick;
        logic [INDEX_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(1) == 1)
                idx = INDEX_W'($urandom_range(511));
            else
                idx = INDEX_W'($urandom());
            if (pick < 40)
                send_request(FUNC_ALLOC, idx);
            else if (pick < 70)
                send_request(FUNC_FREE, idx);
            else if (pick < 94)
                send_request(FUNC_MARK, idx);
            else
                send_request(FUNC_UNUSED, idx);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_ALLOC;
        req_ch.block_index = '0;
        resp_ch.ready      = 1'b0;
        src_idle_pct       = 36;
        sink_idle_pct      = 67;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_FREE, '0);
        send_request(FUNC_ALLOC, 12'h555);
        send_request(FUNC_MARK, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_FREE, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_FREE, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_MARK, 12'd36);
        send_request(FUNC_UNUSED, 12'habc);
        send_request(FUNC_UNUSED, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_MARK, 12'd37);
        send_request(FUNC_ALLOC, 12'haaa);
        send_request(FUNC_FREE, 12'd15);
        send_request(FUNC_FREE, 12'd16);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_MARK, 12'h800);
        send_request(FUNC_FREE, 12'h7ff);
        send_request(FUNC_MARK, 12'h7ff);
        send_request(FUNC_ALLOC, '0);
        drain_requests();

        run_random(550);
        src_idle_pct  = 67;
        sink_idle_pct = 36;
        run_random(550);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(550);

        send_request(FUNC_ALLOC, INDEX_W'($urandom()));
        send_request(FUNC_UNUSED, INDEX_W'($urandom()));
        send_request(FUNC_FREE, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, INDEX_W'(LAST_BLOCK));
        send_request(FUNC_FREE, '0);
        send_request(FUNC_ALLOC, INDEX_W'(LAST_BLOCK));
        for (int k = 0; k < 40; k++)
        begin
            send_request(FUNC_FREE, INDEX_W'($urandom()));
            send_request(FUNC_ALLOC, INDEX_W'($urandom()));
            send_request(FUNC_ALLOC, INDEX_W'($urandom()));
        end
        drain_requests();
        repeat (300) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== bitmap_block_allocator.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_channels.sv
hdl/bba_block_split.sv
hdl/bba_first_clear.sv
hdl/bitmap_block_allocator.sv
sim/alloc_checker.sv
sim/tb_top.sv
